// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rlde_pkg.sv -----
// Package: widths, command types and helper functions of the run-length delta encoder.
package rlde_pkg;

  localparam int MAX_SYMBOL_BITS = 8;
  localparam int WORD_BITS       = 64;
  localparam int LEN_W           = 32;
  localparam int SYM_W           = 8;
  localparam int SB_W            = 4;
  localparam int LOG_W           = $clog2(LEN_W);                  // y: 0..31
  localparam int Z_W             = 3;                              // z: 0..5
  localparam int DELTA_W         = 2 * 5 + 1 + (LEN_W - 1);        // 42
  localparam int CODE_W          = DELTA_W + MAX_SYMBOL_BITS;      // 50
  localparam int CW_W            = $clog2(CODE_W + 1);             // 6
  localparam int USED_W          = $clog2(WORD_BITS);              // 6
  localparam int CNT_W           = $clog2(WORD_BITS + 1);          // 7
  localparam int WIN_W           = 2 * WORD_BITS;
  localparam int SH_W            = $clog2(WIN_W);                  // 7
  localparam int FIFO_DEPTH      = 4;
  localparam int PTR_W           = $clog2(FIFO_DEPTH);
  localparam int APB_DW          = 32;
  localparam int APB_AW          = 2;

  localparam logic [LEN_W-1:0]  LEN_MAX          = '1;
  localparam logic [SB_W-1:0]   SYMBOL_BITS_RST  = SB_W'(3);
  localparam logic [0:0]        FUNC_RUN         = 1'b0;
  localparam logic [0:0]        FUNC_FINISH      = 1'b1;
  localparam logic [APB_AW-1:0] ADDR_SYMBOL_BITS = '0;

  // Front to encoder: one run to code and/or a flush request.
  typedef struct packed {
    logic             run_vld;
    logic [LEN_W-1:0] len;
    logic [SYM_W-1:0] sym;
    logic             flush;
  } run_cmd_t;

  // Encoder to packer: a finished code word of cw bits, right aligned.
  typedef struct packed {
    logic              code_vld;
    logic [CODE_W-1:0] code;
    logic [CW_W-1:0]   cw;
    logic              flush;
  } code_cmd_t;

  // Index of the highest set bit; zero for zero.
  function automatic logic [LOG_W-1:0] flog2(input logic [LEN_W-1:0] v);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 1; i < LEN_W; i++) begin
      if (v[i]) r = LOG_W'(i);
    end
    return r;
  endfunction

  // Clamp the symbol width register into 1..MAX_SYMBOL_BITS.
  function automatic logic [SB_W-1:0] eff_sym_bits(input logic [SB_W-1:0] v);
    logic [SB_W-1:0] r;
    if (v == '0) r = SB_W'(1);
    else if (v > SB_W'(MAX_SYMBOL_BITS)) r = SB_W'(MAX_SYMBOL_BITS);
    else r = v;
    return r;
  endfunction

endpackage

// ----- rtl/core/rlde_front.sv -----
// Front end: accepts run items, merges equal symbols and issues runs to code.
module rlde_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic [rlde_pkg::LEN_W-1:0] in_run_len,
  input  logic [rlde_pkg::SYM_W-1:0] in_symbol,
  input  logic                     q_full,
  output logic                     push,
  output rlde_pkg::run_cmd_t       cmd
);

  logic [rlde_pkg::LEN_W-1:0] pend_len_r, pend_len_nxt;
  logic [rlde_pkg::SYM_W-1:0] pend_sym_r, pend_sym_nxt;
  logic                       has_pend_r, has_pend_nxt;
  logic                       acc;
  logic [rlde_pkg::LEN_W:0]   sum;
  logic [rlde_pkg::LEN_W:0]   rem;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign sum      = {1'b0, pend_len_r} + {1'b0, in_run_len};
  assign rem      = sum - {1'b0, rlde_pkg::LEN_MAX};

  always_comb begin
    pend_len_nxt = pend_len_r;
    pend_sym_nxt = pend_sym_r;
    has_pend_nxt = has_pend_r;
    cmd          = '{run_vld: 1'b0, len: pend_len_r, sym: pend_sym_r, flush: 1'b0};
    if (acc) begin
      if (in_func == rlde_pkg::FUNC_FINISH) begin
        cmd.run_vld  = has_pend_r && (pend_len_r != '0);
        cmd.flush    = 1'b1;
        pend_len_nxt = '0;
        pend_sym_nxt = '0;
        has_pend_nxt = 1'b0;
      end else if (in_run_len != '0) begin
        if (has_pend_r && (in_symbol == pend_sym_r)) begin
          if (sum[rlde_pkg::LEN_W]) begin
            // merged run overflows: code a saturated run, keep the rest
            cmd.run_vld  = 1'b1;
            cmd.len      = rlde_pkg::LEN_MAX;
            pend_len_nxt = rem[rlde_pkg::LEN_W-1:0];
          end else begin
            pend_len_nxt = sum[rlde_pkg::LEN_W-1:0];
          end
        end else begin
          cmd.run_vld  = has_pend_r;
          pend_len_nxt = in_run_len;
          pend_sym_nxt = in_symbol;
          has_pend_nxt = 1'b1;
        end
      end
    end
  end

  assign push = cmd.run_vld || cmd.flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_len_r <= '0;
      pend_sym_r <= '0;
      has_pend_r <= 1'b0;
    end else begin
      pend_len_r <= pend_len_nxt;
      pend_sym_r <= pend_sym_nxt;
      has_pend_r <= has_pend_nxt;
    end
  end

endmodule

// ----- rtl/core/rlde_fifo.sv -----
// Short command queue between the front end and the encoder.
module rlde_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rlde_pkg::run_cmd_t wr_data,
  input  logic               pop,
  output rlde_pkg::run_cmd_t rd_data,
  output logic               full,
  output logic               empty
);

  rlde_pkg::run_cmd_t           mem_r [rlde_pkg::FIFO_DEPTH];
  logic [rlde_pkg::PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [rlde_pkg::PTR_W:0]     count_r;
  logic                         do_push, do_pop;

  assign full    = (count_r == (rlde_pkg::PTR_W+1)'(rlde_pkg::FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- rtl/core/rlde_enc.sv -----
// Encoder stage: turns a run into its Elias delta code followed by the symbol.
module rlde_enc (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  rlde_pkg::run_cmd_t        q_data,
  output logic                      pop,
  input  logic [rlde_pkg::SB_W-1:0] sym_bits,
  output logic                      enc_vld,
  output rlde_pkg::code_cmd_t       enc_cmd,
  input  logic                      pack_ready
);

  logic                            enc_vld_r;
  rlde_pkg::code_cmd_t             enc_cmd_r, enc_cmd_nxt;
  logic                            load;
  logic [rlde_pkg::LOG_W-1:0]      y;
  logic [rlde_pkg::LOG_W:0]        yp1;
  logic [rlde_pkg::Z_W-1:0]        z;
  logic [rlde_pkg::CW_W-1:0]       w;
  logic [rlde_pkg::DELTA_W-1:0]    delta;
  logic [rlde_pkg::SYM_W:0]        sym_mask;
  logic [rlde_pkg::SYM_W-1:0]      sym_code;

  always_comb begin
    y        = rlde_pkg::flog2(q_data.len);
    yp1      = (rlde_pkg::LOG_W+1)'(y) + 1'b1;
    z        = rlde_pkg::Z_W'(rlde_pkg::flog2(rlde_pkg::LEN_W'(yp1)));
    w        = (rlde_pkg::CW_W'(z) << 1) + rlde_pkg::CW_W'(1) + rlde_pkg::CW_W'(y);
    // leading one of the length is replaced by y+1 written above it
    delta    = (rlde_pkg::DELTA_W'(yp1) << y)
             | rlde_pkg::DELTA_W'(q_data.len & ~(rlde_pkg::LEN_W'(1) << y));
    sym_mask = ((rlde_pkg::SYM_W+1)'(1) << sym_bits) - 1'b1;
    sym_code = q_data.sym & sym_mask[rlde_pkg::SYM_W-1:0];
    enc_cmd_nxt.code_vld = q_data.run_vld;
    enc_cmd_nxt.code     = (rlde_pkg::CODE_W'(delta) << sym_bits)
                         | rlde_pkg::CODE_W'(sym_code);
    enc_cmd_nxt.cw       = w + rlde_pkg::CW_W'(sym_bits);
    enc_cmd_nxt.flush    = q_data.flush;
  end

  assign load    = !enc_vld_r || pack_ready;
  assign pop     = load && !q_empty;
  assign enc_vld = enc_vld_r;
  assign enc_cmd = enc_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_vld_r <= 1'b0;
    end else if (load) begin
      enc_vld_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) enc_cmd_r <= enc_cmd_nxt;
  end

endmodule

// ----- rtl/core/rlde_pack.sv -----
// Packer: appends codes MSB first into 64-bit words and drives the result register.
module rlde_pack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          enc_vld,
  input  rlde_pkg::code_cmd_t           enc_cmd,
  output logic                          pack_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rlde_pkg::WORD_BITS-1:0] out_packed_word,
  output logic [rlde_pkg::CNT_W-1:0]    out_bit_count,
  output logic                          out_last
);

  logic [rlde_pkg::WORD_BITS-1:0] buf_r, buf_nxt;
  logic [rlde_pkg::USED_W-1:0]    used_r, used_nxt;
  logic                           fpend_r, fpend_nxt;
  logic                           ovld_r, ovld_nxt;
  logic [rlde_pkg::WORD_BITS-1:0] oword_r, oword_nxt;
  logic [rlde_pkg::CNT_W-1:0]     ocnt_r, ocnt_nxt;
  logic                           olast_r, olast_nxt;

  logic                           out_free, take;
  logic [rlde_pkg::SH_W:0]        sh_full;
  logic [rlde_pkg::WIN_W-1:0]     win;
  logic [rlde_pkg::CNT_W-1:0]     total;
  logic                           a_full;
  logic [rlde_pkg::WORD_BITS-1:0] a_word, a_buf;
  logic [rlde_pkg::USED_W-1:0]    a_used;

  assign out_free   = !ovld_r || !out_stall;
  assign pack_ready = out_free && !fpend_r;
  assign take       = enc_vld && pack_ready;

  // Append: place the code right after the used bits in a two-word window.
  always_comb begin
    sh_full = (rlde_pkg::SH_W+1)'(rlde_pkg::WIN_W) - (rlde_pkg::SH_W+1)'(used_r)
            - (rlde_pkg::SH_W+1)'(enc_cmd.cw);
    win     = {buf_r, {rlde_pkg::WORD_BITS{1'b0}}};
    total   = rlde_pkg::CNT_W'(used_r);
    if (enc_cmd.code_vld) begin
      win   = win | (rlde_pkg::WIN_W'(enc_cmd.code) << sh_full[rlde_pkg::SH_W-1:0]);
      total = total + rlde_pkg::CNT_W'(enc_cmd.cw);
    end
    a_full = total[rlde_pkg::CNT_W-1];
    a_used = total[rlde_pkg::USED_W-1:0];
    a_word = win[rlde_pkg::WIN_W-1:rlde_pkg::WORD_BITS];
    a_buf  = a_full ? win[rlde_pkg::WORD_BITS-1:0] : a_word;
  end

  always_comb begin
    buf_nxt   = buf_r;
    used_nxt  = used_r;
    fpend_nxt = fpend_r;
    ovld_nxt  = out_free ? 1'b0 : ovld_r;
    oword_nxt = oword_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    if (fpend_r && out_free) begin
      // second word of a flush: the partial tail
      ovld_nxt  = 1'b1;
      oword_nxt = buf_r;
      ocnt_nxt  = rlde_pkg::CNT_W'(used_r);
      olast_nxt = 1'b1;
      buf_nxt   = '0;
      used_nxt  = '0;
      fpend_nxt = 1'b0;
    end else if (take) begin
      buf_nxt  = a_buf;
      used_nxt = a_used;
      if (a_full) begin
        ovld_nxt  = 1'b1;
        oword_nxt = a_word;
        ocnt_nxt  = rlde_pkg::CNT_W'(rlde_pkg::WORD_BITS);
        olast_nxt = enc_cmd.flush && (a_used == '0);
        if (enc_cmd.flush) begin
          if (a_used != '0) begin
            fpend_nxt = 1'b1;
          end else begin
            buf_nxt = '0;
          end
        end
      end else if (enc_cmd.flush) begin
        if (a_used != '0) begin
          ovld_nxt  = 1'b1;
          oword_nxt = a_buf;
          ocnt_nxt  = rlde_pkg::CNT_W'(a_used);
          olast_nxt = 1'b1;
        end
        buf_nxt  = '0;
        used_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      used_r  <= '0;
      fpend_r <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      buf_r   <= buf_nxt;
      used_r  <= used_nxt;
      fpend_r <= fpend_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oword_r <= oword_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ovld_r;
  assign out_packed_word = oword_r;
  assign out_bit_count   = ocnt_r;
  assign out_last        = olast_r;

endmodule

// ----- rtl/core/run_length_delta_encoder_top.sv -----
// Top level of the run-length encoder with Elias delta length codes.
//
//  Channel   Direction  Handshake            Payload
//  in_       in         in_valid / in_stall  in_func, in_run_len, in_symbol
//  out_      out        out_valid/out_stall  out_packed_word, out_bit_count, out_last
//  config    in         psel/penable/pready  paddr, pwdata, prdata (symbol_bits)
//
// One input transaction per cycle is sustained while the queue is not full; the front
// end merges runs and pushes at most one command per transaction into a four-entry
// queue. The queue write, the encoder stage and the packer output are registered,
// so a word passes the queue, the encoder register and the result register.
// A finish that yields a full word and a tail puts out the full word, then the tail.
// rst_n is synchronous; it clears the pending run, queue, packer and symbol_bits (3).
// out_stall holds the result register and backs up through the packer and
// encoder into the queue; in_stall rises only when the queue is full.
`include "assert_macros.svh"

module run_length_delta_encoder_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [rlde_pkg::LEN_W-1:0]          in_run_len,
  input  logic [rlde_pkg::SYM_W-1:0]          in_symbol,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rlde_pkg::WORD_BITS-1:0]      out_packed_word,
  output logic [rlde_pkg::CNT_W-1:0]          out_bit_count,
  output logic                                out_last,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rlde_pkg::APB_AW-1:0]         paddr,
  input  logic [rlde_pkg::APB_DW-1:0]         pwdata,
  output logic [rlde_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  // configuration register
  logic [rlde_pkg::SB_W-1:0] sym_bits_r;
  logic [rlde_pkg::SB_W-1:0] sym_bits_eff;
  logic                      cfg_wr;

  // inter-module wiring
  logic                 push, q_full, q_empty, pop;
  rlde_pkg::run_cmd_t   run_cmd, q_data;
  logic                 enc_vld, pack_ready;
  rlde_pkg::code_cmd_t  enc_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == rlde_pkg::ADDR_SYMBOL_BITS);
  assign prdata = (paddr == rlde_pkg::ADDR_SYMBOL_BITS) ?
                  rlde_pkg::APB_DW'(sym_bits_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_bits_r <= rlde_pkg::SYMBOL_BITS_RST;
    end else if (cfg_wr) begin
      sym_bits_r <= pwdata[rlde_pkg::SB_W-1:0];
    end
  end

  // 0 codes as 1 bit, anything above the maximum as the maximum
  assign sym_bits_eff = rlde_pkg::eff_sym_bits(sym_bits_r);

  rlde_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_run_len (in_run_len),
    .in_symbol  (in_symbol),
    .q_full     (q_full),
    .push       (push),
    .cmd        (run_cmd)
  );

  rlde_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (run_cmd),
    .pop     (pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  rlde_enc u_enc (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .pop        (pop),
    .sym_bits   (sym_bits_eff),
    .enc_vld    (enc_vld),
    .enc_cmd    (enc_cmd),
    .pack_ready (pack_ready)
  );

  rlde_pack u_pack (
    .clk             (clk),
    .rst_n           (rst_n),
    .enc_vld         (enc_vld),
    .enc_cmd         (enc_cmd),
    .pack_ready      (pack_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_word (out_packed_word),
    .out_bit_count   (out_bit_count),
    .out_last        (out_last)
  );

  // queue never written while full
  `ASSERT_IMPL(a_no_overflow, push, !q_full, "command pushed into a full queue")
  // encoder only pops real entries
  `ASSERT_IMPL(a_no_underflow, pop, !q_empty, "encoder popped an empty queue")
  // a word shorter than 64 bits only ends a flush
  `ASSERT_IMPL(a_partial_last,
               out_valid && (out_bit_count != rlde_pkg::CNT_W'(rlde_pkg::WORD_BITS)),
               out_last, "partial word without last")
  // a stalled encoder output holds for the packer
  `ASSERT_NEXT(a_enc_hold, enc_vld && !pack_ready, enc_vld && $stable(enc_cmd),
               "encoder output changed while the packer was busy")

endmodule

// ----- dv/rlde_stream_checker.sv -----
`timescale 1ns / 1ps
// Checker: predicts the packed delta-coded words from accepted runs and compares the output.
module rlde_stream_checker
  import rlde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_func,
  input  logic [LEN_W-1:0]     in_run_len,
  input  logic [SYM_W-1:0]     in_symbol,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [WORD_BITS-1:0] out_packed_word,
  input  logic [CNT_W-1:0]     out_bit_count,
  input  logic                 out_last,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  input  logic [APB_DW-1:0]    prdata,
  input  logic                 pready,
  output int                   error_count,
  output int                   words_outstanding
);

  typedef struct {
    logic [WORD_BITS-1:0] word;
    logic [CNT_W-1:0]     count;
    logic                 last_flag;
  } packed_word_t;

  packed_word_t expected_words[$];
  packed_word_t head;

  // shadow of symbol_bits and of the encoder state
  logic [SB_W-1:0]      sym_bits_reg;
  logic [LEN_W-1:0]     run_len_acc;
  logic [SYM_W-1:0]     run_sym;
  bit                   run_open;
  logic [WORD_BITS-1:0] word_acc;
  int                   free_bits;
  int                   words_this_item;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int clamp_sym_bits(input logic [SB_W-1:0] v);
    if (v == '0) return 1;
    if (v > SB_W'(MAX_SYMBOL_BITS)) return MAX_SYMBOL_BITS;
    return int'(v);
  endfunction

  function automatic int msb_index(input logic [63:0] v);
    int r;
    r = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = i;
    end
    return r;
  endfunction

  task automatic push_word(input logic [WORD_BITS-1:0] w, input int cnt);
    expected_words.push_back('{w, CNT_W'(cnt), 1'b0});
    words_this_item++;
  endtask

  // MSB-first packing; a full word goes out at once
  task automatic pack_bits(input logic [63:0] code, input int width);
    int spill;
    if (width < free_bits) begin
      free_bits -= width;
      word_acc |= code << free_bits;
    end else begin
      spill = width - free_bits;
      word_acc |= code >> spill;
      push_word(word_acc, WORD_BITS);
      word_acc = (spill == 0) ? '0 : code << (WORD_BITS - spill);
      free_bits = WORD_BITS - spill;
    end
  endtask

  // Elias delta code of the length, then the low symbol bits
  task automatic code_run(input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym);
    int sb, y, z;
    logic [63:0] body, code;
    sb = clamp_sym_bits(sym_bits_reg);
    y = msb_index(64'(len));
    z = msb_index(64'(y + 1));
    body = (64'(y + 1) << y) | (64'(len) & ((64'd1 << y) - 64'd1));
    code = (body << sb) | (64'(sym) & ((64'd1 << sb) - 64'd1));
    pack_bits(code, 2 * z + 1 + y + sb);
  endtask

  task automatic take_item(input logic func, input logic [LEN_W-1:0] len,
                           input logic [SYM_W-1:0] sym);
    logic [LEN_W:0] sum;
    words_this_item = 0;
    if (func == FUNC_RUN) begin
      if (len != '0) begin
        if (run_open && sym == run_sym) begin
          sum = {1'b0, run_len_acc} + len;
          // saturated merge: code a maximal run, keep the rest pending
          if (sum > {1'b0, LEN_MAX}) begin
            code_run(LEN_MAX, run_sym);
            sum -= {1'b0, LEN_MAX};
          end
          run_len_acc = sum[LEN_W-1:0];
        end else begin
          if (run_open) code_run(run_len_acc, run_sym);
          run_len_acc = len;
          run_sym = sym;
          run_open = 1'b1;
        end
      end
    end else begin
      if (run_open && run_len_acc != '0) code_run(run_len_acc, run_sym);
      if (free_bits < WORD_BITS) push_word(word_acc, WORD_BITS - free_bits);
      if (words_this_item > 0) expected_words[$].last_flag = 1'b1;
      run_len_acc = '0;
      run_sym = '0;
      run_open = 1'b0;
      word_acc = '0;
      free_bits = WORD_BITS;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sym_bits_reg = SYMBOL_BITS_RST;
      run_len_acc = '0;
      run_sym = '0;
      run_open = 1'b0;
      word_acc = '0;
      free_bits = WORD_BITS;
      expected_words.delete();
      error_count = 0;
    end else begin
      if (psel && penable && pready && paddr == ADDR_SYMBOL_BITS) begin
        if (pwrite) begin
          sym_bits_reg = pwdata[SB_W-1:0];
        end else if (prdata !== APB_DW'(sym_bits_reg)) begin
          report_mismatch($sformatf("symbol_bits read %h, predicted %h", prdata, sym_bits_reg));
        end
      end
      if (in_valid && !in_stall) take_item(in_func, in_run_len, in_symbol);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h/%0d/%0b",
                                    out_packed_word, out_bit_count, out_last));
        end else begin
          head = expected_words.pop_front();
          if (out_packed_word !== head.word || out_bit_count !== head.count ||
              out_last !== head.last_flag) begin
            report_mismatch($sformatf("word %h/%0d/%0b, predicted %h/%0d/%0b",
                                      out_packed_word, out_bit_count, out_last,
                                      head.word, head.count, head.last_flag));
          end
        end
      end
    end
    words_outstanding = expected_words.size();
  end

endmodule

// ----- dv/run_length_delta_encoder_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: stimulus, idling, configuration and verdict for the run-length delta encoder.
module run_length_delta_encoder_top_tb;
  import rlde_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 16;    // pipeline plus queue, with margin
  localparam int HOLD_CYCLES  = 300;   // long output hold-off, fills the queue
  localparam int QUIET_LIMIT  = 5000;  // watchdog: cycles without any transaction
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 125;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_func;
  logic [LEN_W-1:0]     in_run_len;
  logic [SYM_W-1:0]     in_symbol;
  logic                 out_valid;
  logic                 out_stall;
  logic [WORD_BITS-1:0] out_packed_word;
  logic [CNT_W-1:0]     out_bit_count;
  logic                 out_last;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  int check_errors;
  int words_outstanding;

  // idling knobs, percent per cycle
  int idle_pct;
  int stall_pct;
  bit hold_req;

  // bookkeeping for the summary
  int items_sent;
  int finishes_sent;
  int words_seen;
  int widths_used;
  int quiet;

  logic [SB_W-1:0]  sym_bits_now;
  logic [SYM_W-1:0] prev_sym;

  int phase_sb[PHASES]    = '{0, 8, 1, 15, 5, 2};
  int phase_idle[PHASES]  = '{0, 50, 0, 37, 0, 37};
  int phase_stall[PHASES] = '{0, 0, 50, 37, 0, 37};

  run_length_delta_encoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_run_len      (in_run_len),
    .in_symbol       (in_symbol),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_word (out_packed_word),
    .out_bit_count   (out_bit_count),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Checker sits beside the block and only watches its ports.
  rlde_stream_checker stream_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_run_len        (in_run_len),
    .in_symbol         (in_symbol),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packed_word   (out_packed_word),
    .out_bit_count     (out_bit_count),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .error_count       (check_errors),
    .words_outstanding (words_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side. Random stall each cycle; on request a long hold-off,
  // counted here, while the sender keeps offering transactions.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: any accepted transaction on any port restarts the count.
  initial begin
    quiet = 0;
    words_seen = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (out_valid && !out_stall) words_seen++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // One input transaction; random idle cycles ahead of it, payload held while stalled.
  task automatic send_run(input logic func, input logic [LEN_W-1:0] len,
                          input logic [SYM_W-1:0] sym);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= func;
    in_run_len <= len;
    in_symbol  <= sym;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (func == FUNC_FINISH) finishes_sent++;
  endtask

  // Setup cycle then access cycle; pready is honored even though it stays high.
  task automatic cfg_access(input bit wr, input logic [SB_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_SYMBOL_BITS;
    pwdata  <= {$urandom} & ~APB_DW'({SB_W{1'b1}}) | APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (wr) sym_bits_now = val;
  endtask

  // Stop offering, then wait until every predicted word is out and the
  // pipeline has had time to swallow transactions that make no word.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      while (words_outstanding != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (words_outstanding != 0);
  endtask

  // Random run: mostly in-range symbols, frequent repeats so runs merge,
  // small lengths mostly, with full-range and near-saturation lengths mixed in.
  task automatic send_random_item();
    logic [LEN_W-1:0] len;
    logic [SYM_W-1:0] sym;
    int eff, pick;
    eff = (sym_bits_now == '0) ? 1 :
          (sym_bits_now > SB_W'(MAX_SYMBOL_BITS)) ? MAX_SYMBOL_BITS : int'(sym_bits_now);
    if ($urandom_range(99) < 4) begin
      send_run(FUNC_FINISH, $urandom, SYM_W'($urandom));
      return;
    end
    pick = $urandom_range(99);
    if (pick < 30) sym = prev_sym;
    else if (pick < 88) sym = SYM_W'($urandom_range((1 << eff) - 1));
    else sym = SYM_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 5) len = '0;
    else if (pick < 55) len = LEN_W'($urandom_range(1, 16));
    else if (pick < 78) len = LEN_W'($urandom_range(17, 4096));
    else if (pick < 92) len = $urandom;
    else len = LEN_MAX - LEN_W'($urandom_range(0, 255));
    prev_sym = sym;
    send_run(FUNC_RUN, len, sym);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_func    = FUNC_RUN;
    in_run_len = '0;
    in_symbol  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_req   = 1'b0;
    items_sent = 0;
    finishes_sent = 0;
    widths_used = 1;
    sym_bits_now = SYMBOL_BITS_RST;
    prev_sym = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of symbol_bits, checked by the read-back
    cfg_access(1'b0, '0);

    // Directed part, symbol_bits = 3.
    send_run(FUNC_FINISH, '0, '0);                     // nothing to flush: no word
    send_run(FUNC_RUN, '0, SYM_W'(5));                 // zero length ignored
    send_run(FUNC_RUN, LEN_MAX, SYM_W'(1));            // 45-bit code
    send_run(FUNC_RUN, LEN_W'(512), SYM_W'(2));        // 19-bit code
    send_run(FUNC_FINISH, LEN_W'(32'hDEAD_BEEF), SYM_W'(8'hA5)); // word exactly full, last
    send_run(FUNC_RUN, LEN_W'(1), '0);
    send_run(FUNC_RUN, '0, '0);                        // ignored while a run is open
    send_run(FUNC_RUN, LEN_W'(3), '0);                 // merge
    send_run(FUNC_RUN, LEN_MAX, '0);                   // merge saturates, split
    send_run(FUNC_RUN, LEN_MAX - 1, '0);               // saturates again
    send_run(FUNC_RUN, LEN_W'(32'h8000_0000), SYM_W'(8'hFF)); // symbol wider than field
    send_run(FUNC_RUN, LEN_W'(7), SYM_W'(8'hF7));      // same low bits, no merge
    send_run(FUNC_RUN, LEN_W'(7), SYM_W'(8'h07));
    send_run(FUNC_RUN, LEN_W'(32'h5555_5555), SYM_W'(8'hAA));
    send_run(FUNC_RUN, LEN_W'(32'hAAAA_AAAA), SYM_W'(8'h55));
    send_run(FUNC_FINISH, LEN_MAX, SYM_W'(8'hFF));
    wait_drained();

    // Random phases: new width, then a mix of idling modes.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) phase_sb[p] = $urandom_range(2, 7);
      cfg_access(1'b1, SB_W'(phase_sb[p]));
      cfg_access(1'b0, '0);
      widths_used++;
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      // back-pressure test: receiver holds off while the sender runs flat out
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
      wait_drained();
    end

    // flush whatever is still pending
    idle_pct = 0;
    send_run(FUNC_FINISH, '0, '0);
    wait_drained();

    $display("Summary: %0d input transactions (%0d finish), %0d output words checked,",
             items_sent, finishes_sent, words_seen);
    $display("Summary: %0d symbol widths incl. out-of-range, idle/stall mixes, %0d-cycle hold-off",
             widths_used, HOLD_CYCLES);
    if (check_errors == 0 && words_outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
